[hw/rtl/ilwf_pkg.sv]
// ============================================================================
// ilwf_pkg
// Shared types and constants for the instrument lookup unit.
// ============================================================================
package ilwf_pkg;

    localparam int TABLE_DEPTH = 256;

    // Field widths
    localparam int IDX_W   = 8;
    localparam int BANK_W  = 7;
    localparam int PROG_W  = 7;
    localparam int CFG_W   = 9;
    localparam int LEVEL_W = 2;

    // Stored identity: drum, bank MSB, bank LSB, program. The upper three bits
    // of the architectural 25-bit entry are always zero and are not stored.
    localparam int ENTRY_W = 1 + BANK_W + BANK_W + PROG_W;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = ($clog2(TABLE_DEPTH + 1) > CFG_W) ?
                            $clog2(TABLE_DEPTH + 1) : CFG_W;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic [LEVEL_W-1:0] LVL_EXACT     = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_BANK_ZERO = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_ALL_ZERO  = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_DEFAULT   = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load_key;
        logic table_we;
        logic scan_rd;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic out_free;
    } t_status;

endpackage

[hw/rtl/ilwf_ram.sv]
// ============================================================================
// ilwf_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ============================================================================
module ilwf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/ilwf_ctrl.sv]
// ============================================================================
// ilwf_ctrl
// Sequencer for table writes and the one-entry-per-cycle lookup scan.
// ============================================================================
module ilwf_ctrl
    import ilwf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_func,
    input  t_status i_status,
    output logic    o_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && (i_func == FUNC_LOOKUP)) begin
                    n_state = i_status.count_zero ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready        = 1'b0;
        o_cmd          = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ready        = 1'b1;
                o_cmd.load_key = i_valid && (i_func == FUNC_LOOKUP);
                o_cmd.table_we = i_valid && (i_func == FUNC_WRITE);
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
            end
            S_DRAIN: begin
                o_cmd = '0;
            end
            S_FINISH: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    // Reads and writes of the table never overlap
    a_no_wr_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.table_we && o_cmd.scan_rd))
        else $error("table write during scan");

endmodule

[hw/rtl/ilwf_dp.sv]
// ============================================================================
// ilwf_dp
// Table storage, three-tier match tracking and the result register.
// ============================================================================
module ilwf_dp
    import ilwf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  t_cmd               i_cmd,
    input  logic [IDX_W-1:0]   i_entry_index,
    input  logic               i_drum_flag,
    input  logic [BANK_W-1:0]  i_bank_high,
    input  logic [BANK_W-1:0]  i_bank_low,
    input  logic [PROG_W-1:0]  i_program_req,
    input  logic               i_ready,
    output t_status            o_status,
    output logic               o_valid,
    output logic [IDX_W-1:0]   o_found_index,
    output logic [LEVEL_W-1:0] o_match_level
);

    logic [CFG_W-1:0]   r_count;
    logic [CNT_W-1:0]   count_eff;
    logic [CNT_W-1:0]   cfg_ext;

    logic [ENTRY_W-1:0] r_key;
    logic [ADDR_W-1:0]  r_addr;
    logic               r_cmp_vld;
    logic [ADDR_W-1:0]  r_cmp_idx;
    logic [ENTRY_W-1:0] rdata;

    logic [2:0]         r_hit;
    logic [ADDR_W-1:0]  r_hit_idx [3];
    logic [2:0]         match;

    logic               r_o_valid;
    logic [IDX_W-1:0]   r_found;
    logic [LEVEL_W-1:0] r_level;
    logic [IDX_W-1:0]   n_found;
    logic [LEVEL_W-1:0] n_level;

    logic               wr_en;

    // Entry count, clamped to the table depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_data;
        end
    end

    assign cfg_ext   = CNT_W'(r_count);
    assign count_eff = (cfg_ext > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : cfg_ext;

    assign wr_en = i_cmd.table_we && (CNT_W'(i_entry_index) < CNT_W'(TABLE_DEPTH));

    ilwf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (ADDR_W'(i_entry_index)),
        .i_wdata ({i_drum_flag, i_bank_high, i_bank_low, i_program_req}),
        .i_re    (i_cmd.scan_rd),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    // Scan address and compare pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_key) begin
            r_key  <= {i_drum_flag, i_bank_high, i_bank_low, i_program_req};
            r_addr <= '0;
        end else if (i_cmd.scan_rd) begin
            r_addr <= r_addr + 1'b1;
        end
        r_cmp_idx <= r_addr;
    end

    // Tier keys: exact, banks zeroed, banks and program zeroed
    assign match[0] = (rdata == r_key);
    assign match[1] = (rdata == {r_key[ENTRY_W-1], {(2*BANK_W){1'b0}},
                                 r_key[PROG_W-1:0]});
    assign match[2] = (rdata == {r_key[ENTRY_W-1], {(ENTRY_W-1){1'b0}}});

    // First hit per tier; later hits in the same tier are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= '0;
        end else if (i_cmd.load_key) begin
            r_hit <= '0;
        end else if (r_cmp_vld) begin
            r_hit <= r_hit | match;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int t = 0; t < 3; t++) begin
            if (r_cmp_vld && match[t] && !r_hit[t]) begin
                r_hit_idx[t] <= r_cmp_idx;
            end
        end
    end

    always_comb begin
        n_found = '0;
        n_level = LVL_DEFAULT;
        if (r_hit[0]) begin
            n_found = IDX_W'(r_hit_idx[0]);
            n_level = LVL_EXACT;
        end else if (r_hit[1]) begin
            n_found = IDX_W'(r_hit_idx[1]);
            n_level = LVL_BANK_ZERO;
        end else if (r_hit[2]) begin
            n_found = IDX_W'(r_hit_idx[2]);
            n_level = LVL_ALL_ZERO;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_found <= n_found;
            r_level <= n_level;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_found_index = r_found;
    assign o_match_level = r_level;

    assign o_status.count_zero = (count_eff == '0);
    assign o_status.scan_last  = (CNT_W'(r_addr) == count_eff - 1'b1);
    assign o_status.out_free   = !r_o_valid || i_ready;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_o_valid || i_ready))
        else $error("result overwritten before transaction completed");

    a_default_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_level == LVL_DEFAULT)) |-> (r_found == '0))
        else $error("default level with non-zero index");

    a_no_cmp_at_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !r_cmp_vld)
        else $error("result taken while a compare is still in flight");

endmodule

[hw/rtl/instrument_lookup_with_fallback_unit.sv]
// ============================================================================
// instrument_lookup_with_fallback_unit
// Instrument table with exact / bank-zero / all-zero fallback lookup.
// ============================================================================
// A write transaction (func 0) stores an identity and gives no result. A
// lookup transaction (func 1) scans slots 0 to N-1, N being entry_count
// clamped to the table depth, one slot per cycle through the table's single
// read port, and then loads its result into the output register. One lookup
// is in work at a time; input is accepted again once the result is in the
// output register, which holds it until taken.
module instrument_lookup_with_fallback_unit
    import ilwf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_func,
    input  logic [IDX_W-1:0]   i_entry_index,
    input  logic               i_drum_flag,
    input  logic [BANK_W-1:0]  i_bank_high,
    input  logic [BANK_W-1:0]  i_bank_low,
    input  logic [PROG_W-1:0]  i_program_req,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [IDX_W-1:0]   o_found_index,
    output logic [LEVEL_W-1:0] o_match_level
);

    t_cmd    cmd;
    t_status status;

    ilwf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_func   (i_func),
        .i_status (status),
        .o_ready  (o_ready),
        .o_cmd    (cmd)
    );

    ilwf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .i_entry_index (i_entry_index),
        .i_drum_flag   (i_drum_flag),
        .i_bank_high   (i_bank_high),
        .i_bank_low    (i_bank_low),
        .i_program_req (i_program_req),
        .i_ready       (i_ready),
        .o_status      (status),
        .o_valid       (o_valid),
        .o_found_index (o_found_index),
        .o_match_level (o_match_level)
    );

endmodule
